[design/hbs_pkg.sv]
// shared constants and types for the height map smoothing core
// no dependencies; imported by every module of the block
`default_nettype none

package hbs_pkg;

  localparam int MAX_GRID  = 256;
  localparam int COORD_W   = $clog2(MAX_GRID);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int GRID_W    = COORD_W + 1;
  localparam int H_W       = 32;
  localparam int SMOOTH_W  = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE   = SMOOTH_W'(1 << FRAC_W);
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(1 << (FRAC_W - 1));
  localparam logic [GRID_W-1:0]   GRID_MAX     = GRID_W'(MAX_GRID);

  // register index, taken from the word address of the config port
  localparam logic REG_SMOOTHING = 1'b0;
  localparam logic REG_GRID_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_FILTER = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

endpackage

`default_nettype wire

[design/hbs_blend.sv]
// one-pole blend unit: new = cur + floor(weight * (prev - cur) / 2^16), saturated
// two steps: product register, then add and clamp; uses hbs_pkg
`default_nettype none

module hbs_blend (
  input  wire logic                              clk,
  input  wire logic                              load,
  input  wire logic signed [hbs_pkg::H_W-1:0]    prev,
  input  wire logic signed [hbs_pkg::H_W-1:0]    cur,
  input  wire logic        [hbs_pkg::SMOOTH_W-1:0] weight,
  output logic signed      [hbs_pkg::H_W-1:0]    result
);
  import hbs_pkg::*;

  localparam int PROD_W = SMOOTH_W + 1 + H_W + 1;
  localparam int SUM_W  = PROD_W - FRAC_W;

  logic signed [H_W:0]        diff;
  logic signed [SMOOTH_W:0]   wgt;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [H_W-1:0]      cur_r;
  logic signed [SUM_W-1:0]    quot;
  logic signed [SUM_W-1:0]    sum;

  always_comb begin
    diff     = {prev[H_W-1], prev} - {cur[H_W-1], cur};
    wgt      = {1'b0, weight};
    prod_nxt = diff * wgt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      cur_r  <= cur;
    end
  end

  // arithmetic shift gives the floor for negative products
  always_comb begin
    quot = prod_r[PROD_W-1:FRAC_W];
    sum  = {{(SUM_W-H_W){cur_r[H_W-1]}}, cur_r} + quot;
    if (sum[SUM_W-1:H_W-1] == '0 || sum[SUM_W-1:H_W-1] == '1) begin
      result = sum[H_W-1:0];
    end else if (sum[SUM_W-1]) begin
      result = {1'b1, {(H_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(H_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[design/heightmap_bidirectional_smoothing_core.sv]
// result timing: a write, an unused opcode or a read with an out-of-range coordinate
//   loads the result register directly; any other read answers from the registered
//   map read data; a filter answers directly when the used grid side n is 1
// throughput: writes one word per cycle while out_ready drains results; a read blocks the
//   input until its data returns; a filtered cell is read, then blended and written back
// reset: synchronous active low; registers return to smoothing 0.5, grid 256,
//   the map ram is not cleared
`default_nettype none

module heightmap_bidirectional_smoothing_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [hbs_pkg::COORD_W-1:0]       in_column,
  input  wire logic [hbs_pkg::COORD_W-1:0]       in_row,
  input  wire logic signed [hbs_pkg::H_W-1:0]    in_height_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hbs_pkg::H_W-1:0]         out_height_out,
  output logic                                   out_status,
  // config port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [hbs_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [hbs_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [hbs_pkg::CFG_DW-1:0]             cfg_prdata,
  output logic                                   cfg_pready
);
  import hbs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // waiting for a word
    S_RDWAIT = 6'b000010,  // map read in flight for a read word
    S_LSTART = 6'b000100,  // fetch first cell of a line
    S_FIRST  = 6'b001000,  // first cell seeds the running value
    S_MUL    = 6'b010000,  // cell data back, product registered
    S_WR     = 6'b100000   // blended value written back, next cell fetched
  } state_t;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [SMOOTH_W-1:0] smoothing_r, smoothing_nxt;
  logic [GRID_W-1:0]   grid_size_r, grid_size_nxt;
  logic                cfg_wr;
  logic                cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_comb begin
    smoothing_nxt = smoothing_r;
    grid_size_nxt = grid_size_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SMOOTHING: smoothing_nxt = cfg_pwdata[SMOOTH_W-1:0];
        REG_GRID_SIZE: grid_size_nxt = cfg_pwdata[GRID_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SMOOTHING: cfg_prdata = CFG_DW'(smoothing_r);
      REG_GRID_SIZE: cfg_prdata = CFG_DW'(grid_size_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // effective grid side and weight after clamping
  logic [GRID_W-1:0]   used_n;
  logic [GRID_W-1:0]   used_m1;
  logic [COORD_W-1:0]  last_idx;
  logic [SMOOTH_W-1:0] weight;

  always_comb begin
    if (grid_size_r == '0) begin
      used_n = GRID_W'(1);
    end else if (grid_size_r > GRID_MAX) begin
      used_n = GRID_MAX;
    end else begin
      used_n = grid_size_r;
    end
    used_m1  = used_n - GRID_W'(1);
    last_idx = used_m1[COORD_W-1:0];
    weight   = (smoothing_r > SMOOTH_ONE) ? SMOOTH_ONE : smoothing_r;
  end

  // ---------------------------------------------------------------------------
  // map ram: one write port, one read port, registered read data
  // ---------------------------------------------------------------------------
  logic [H_W-1:0]    map_mem [MAX_GRID*MAX_GRID];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [H_W-1:0]    mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [H_W-1:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= map_mem[mem_ra];
    end
  end

  // cell address along the current pass: pass bit 0 walks downward,
  // pass bit 1 walks columns instead of rows; address is row*MAX_GRID+column
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [1:0]         pass,
    input logic [COORD_W-1:0] line,
    input logic [COORD_W-1:0] pos,
    input logic [COORD_W-1:0] last
  );
    logic [COORD_W-1:0] idx;
    idx = pass[0] ? (last - pos) : pos;
    return pass[1] ? {idx, line} : {line, idx};
  endfunction

  // ---------------------------------------------------------------------------
  // blend unit
  // ---------------------------------------------------------------------------
  logic                  blend_load;
  logic signed [H_W-1:0] blend_res;
  logic signed [H_W-1:0] prev_r, prev_nxt;

  hbs_blend u_blend (
    .clk    (clk),
    .load   (blend_load),
    .prev   (prev_r),
    .cur    (rdata_r),
    .weight (weight),
    .result (blend_res)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [1:0]         pass_r, pass_nxt;
  logic [COORD_W-1:0] line_r, line_nxt;
  logic [COORD_W-1:0] pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [H_W-1:0]     out_height_r, out_height_nxt;
  logic               out_status_r, out_status_nxt;
  logic               in_acc;
  logic               coord_bad;

  // a new word is taken only when the result register is empty or draining
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign coord_bad = (in_column > last_idx) || (in_row > last_idx);

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    line_nxt       = line_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r;
    out_height_nxt = out_height_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;
    blend_load     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_t'(in_opcode))
            OP_WRITE: begin
              mem_we         = !coord_bad;
              mem_wa         = {in_row, in_column};
              mem_wd         = in_height_in;
              out_valid_nxt  = 1'b1;
              out_height_nxt = '0;
              out_status_nxt = coord_bad;
            end
            OP_READ: begin
              if (coord_bad) begin
                out_valid_nxt  = 1'b1;
                out_height_nxt = '0;
                out_status_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = {in_row, in_column};
                state_nxt = S_RDWAIT;
              end
            end
            OP_FILTER: begin
              // a one-cell map has nothing to smooth
              if (last_idx == '0) begin
                out_valid_nxt  = 1'b1;
                out_height_nxt = '0;
                out_status_nxt = 1'b0;
              end else begin
                pass_nxt  = '0;
                line_nxt  = '0;
                state_nxt = S_LSTART;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_height_nxt = '0;
              out_status_nxt = 1'b0;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        out_valid_nxt  = 1'b1;
        out_height_nxt = rdata_r;
        out_status_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      S_LSTART: begin
        mem_re    = 1'b1;
        mem_ra    = cell_addr(pass_r, line_r, '0, last_idx);
        state_nxt = S_FIRST;
      end

      S_FIRST: begin
        prev_nxt  = rdata_r;
        mem_re    = 1'b1;
        mem_ra    = cell_addr(pass_r, line_r, COORD_W'(1), last_idx);
        pos_nxt   = COORD_W'(1);
        state_nxt = S_MUL;
      end

      S_MUL: begin
        blend_load = 1'b1;
        state_nxt  = S_WR;
      end

      S_WR: begin
        // the next cell's read never hits the cell being written
        mem_we   = 1'b1;
        mem_wa   = cell_addr(pass_r, line_r, pos_r, last_idx);
        mem_wd   = blend_res;
        prev_nxt = blend_res;
        if (pos_r == last_idx) begin
          if (line_r == last_idx) begin
            if (pass_r == 2'd3) begin
              out_valid_nxt  = 1'b1;
              out_height_nxt = '0;
              out_status_nxt = 1'b0;
              state_nxt      = S_IDLE;
            end else begin
              pass_nxt  = pass_r + 2'd1;
              line_nxt  = '0;
              state_nxt = S_LSTART;
            end
          end else begin
            line_nxt  = line_r + COORD_W'(1);
            state_nxt = S_LSTART;
          end
        end else begin
          pos_nxt   = pos_r + COORD_W'(1);
          mem_re    = 1'b1;
          mem_ra    = cell_addr(pass_r, line_r, pos_r + COORD_W'(1), last_idx);
          state_nxt = S_MUL;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      smoothing_r <= SMOOTH_RESET;
      grid_size_r <= GRID_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      smoothing_r <= smoothing_nxt;
      grid_size_r <= grid_size_nxt;
    end
  end

  // walk counters and payload
  always_ff @(posedge clk) begin
    pass_r       <= pass_nxt;
    line_r       <= line_nxt;
    pos_r        <= pos_nxt;
    prev_r       <= prev_nxt;
    out_height_r <= out_height_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_height_out = out_height_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[design/hbs_checker.sv]
// port-level checks for the height map smoothing core, bound to the top level
// uses hbs_pkg for opcodes
`default_nettype none

module hbs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [1:0]                     in_opcode,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [hbs_pkg::H_W-1:0] out_height_out,
  input wire logic                           out_status,
  input wire logic                           cfg_pready
);
  import hbs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height_out) && $stable(out_status))
    else $error("result changed while stalled");

  // an ignored coordinate never reports a height
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_height_out == '0)
    else $error("flagged result carries a height");

  // a write or unused opcode answers in the next cycle with zero height
  a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_WRITE || in_opcode == OP_NOP)
    |=> out_valid && out_height_out == '0)
    else $error("write result missing");

  // a new word is never taken while the result register stays full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_ready)
    else $error("input taken over a pending result");

  // the config port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port stalled");

endmodule

bind heightmap_bidirectional_smoothing_core hbs_checker u_hbs_checker (.*);

`default_nettype wire
